// ----- rtl/core/erd_pkg.sv -----
package erd_pkg;

  // Default number of replica bytes in an id
  localparam int DEF_REPLICA_BYTES = 16;

  // Reset value of the expected version register
  localparam logic [7:0] DEF_EXPECTED_VERSION = 8'd1;

  // Field kinds
  localparam logic [3:0] FK_KIND      = 4'd0;
  localparam logic [3:0] FK_COUNTER   = 4'd1;
  localparam logic [3:0] FK_REPLICA   = 4'd2;
  localparam logic [3:0] FK_PCOUNTER  = 4'd3;
  localparam logic [3:0] FK_PREPLICA  = 4'd4;
  localparam logic [3:0] FK_SIDE      = 4'd5;
  localparam logic [3:0] FK_LENGTH    = 4'd6;
  localparam logic [3:0] FK_CODEPOINT = 4'd7;
  localparam logic [3:0] FK_COUNT     = 4'd8;
  localparam logic [3:0] FK_VERDICT   = 4'd9;

  // Verdict codes
  localparam logic [3:0] VC_OK         = 4'd0;
  localparam logic [3:0] VC_TRUNCATED  = 4'd1;
  localparam logic [3:0] VC_VERSION    = 4'd2;
  localparam logic [3:0] VC_KIND       = 4'd3;
  localparam logic [3:0] VC_ZERO_CTR   = 4'd4;
  localparam logic [3:0] VC_SIDE       = 4'd5;
  localparam logic [3:0] VC_ZERO_LEN   = 4'd6;
  localparam logic [3:0] VC_RANGE      = 4'd7;
  localparam logic [3:0] VC_SURROGATE  = 4'd8;
  localparam logic [3:0] VC_ZERO_COUNT = 4'd9;
  localparam logic [3:0] VC_TRAILING   = 4'd10;

  // Code point limits
  localparam logic [31:0] CP_MAX        = 32'h0010_FFFF;
  localparam logic [31:0] CP_SURR_FIRST = 32'h0000_D800;
  localparam logic [31:0] CP_SURR_LAST  = 32'h0000_DFFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_payload;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  field_kind;
    logic [63:0] field_value;
    logic [3:0]  verdict_code;
    logic        record_end;
  } out_item_t;

endpackage

// ----- rtl/core/edit_op_record_decoder.sv -----
// Channel  Direction  Handshake              Beat
// in       in         in_valid / in_ready    one payload byte and end flag
// out      out        out_valid / out_ready  one decoded field or verdict
// cfg      in         cfg_valid / cfg_ready  expected version byte
//
// One byte is parsed in the cycle it is accepted; its results go into a
// four-entry result queue and leave on out from there, one per beat.
// A byte giving a field and a verdict takes two output beats; in_ready
// stays high while the queue has at least two free entries, so a byte a cycle runs
// when the consumer keeps up. cfg_ready is always high.
// Reset clears the parse state and the queue and sets the version to 1.
module edit_op_record_decoder
  import erd_pkg::*;
#(
  parameter int REPLICA_BYTES = DEF_REPLICA_BYTES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  // Parse phases
  localparam logic [3:0] PH_VERSION  = 4'd0;
  localparam logic [3:0] PH_KIND     = 4'd1;
  localparam logic [3:0] PH_COUNTER  = 4'd2;
  localparam logic [3:0] PH_REPLICA  = 4'd3;
  localparam logic [3:0] PH_PCOUNTER = 4'd4;
  localparam logic [3:0] PH_PREPLICA = 4'd5;
  localparam logic [3:0] PH_SIDE     = 4'd6;
  localparam logic [3:0] PH_LENGTH   = 4'd7;
  localparam logic [3:0] PH_CHARS    = 4'd8;
  localparam logic [3:0] PH_COUNT    = 4'd9;
  localparam logic [3:0] PH_DONE     = 4'd10;

  // Byte counter spans the longest field
  localparam int MAXF = (REPLICA_BYTES > 8) ? REPLICA_BYTES : 8;
  localparam int BW   = $clog2(MAXF);
  localparam logic [BW:0] REP_N  = (BW+1)'(REPLICA_BYTES);
  localparam logic [BW:0] WORD_N = (BW+1)'(8);
  localparam logic [BW:0] HALF_N = (BW+1)'(4);

  // Parse state
  logic [7:0]    expected_version;
  logic [3:0]    parse_phase,       parse_phase_next;
  logic [BW-1:0] byte_in_field,     byte_in_field_next;
  logic [63:0]   field_accumulator, field_accumulator_next;
  logic          record_is_delete,  record_is_delete_next;
  logic [31:0]   chars_remaining,   chars_remaining_next;
  logic [3:0]    first_error,       first_error_next;
  logic          has_failed,        has_failed_next;

  // Result queue
  out_item_t     queue [4];
  logic [1:0]    wr_ptr;
  logic [1:0]    rd_ptr;
  logic [2:0]    count;

  logic          in_fire;
  logic          out_fire;
  logic [7:0]    b;
  logic          last;

  // Gather helpers
  logic [BW:0]   bif_inc;
  logic [63:0]   acc_g;
  logic [31:0]   cp;
  logic [31:0]   chars_dec;

  logic          fld_valid;
  logic [3:0]    fld_kind;
  logic [63:0]   fld_value;
  logic [3:0]    verdict;
  out_item_t     ent0, ent1;
  logic [1:0]    push_cnt;

  assign cfg_ready = 1'b1;
  assign in_ready  = (count <= 3'd2);
  assign in_fire   = in_valid & in_ready;
  assign out_valid = (count != 3'd0);
  assign out_fire  = out_valid & out_ready;
  assign out_data  = queue[rd_ptr];

  assign b    = in_data.data_byte;
  assign last = in_data.end_of_payload;

  // Little-endian byte insert into the accumulator
  always_comb begin
    bif_inc = {1'b0, byte_in_field} + (BW+1)'(1);
    acc_g   = ((byte_in_field == '0) ? 64'd0 : field_accumulator)
              | ({56'd0, b} << {byte_in_field[2:0], 3'b000});
    cp        = acc_g[31:0];
    chars_dec = (chars_remaining != 32'd0) ? chars_remaining - 32'd1 : chars_remaining;
  end

  // Phase step for one byte
  always_comb begin
    parse_phase_next       = parse_phase;
    byte_in_field_next     = byte_in_field;
    field_accumulator_next = field_accumulator;
    record_is_delete_next  = record_is_delete;
    chars_remaining_next   = chars_remaining;
    first_error_next       = first_error;
    has_failed_next        = has_failed;
    fld_valid              = 1'b0;
    fld_kind               = FK_KIND;
    fld_value              = 64'd0;

    if (!has_failed) begin
      unique case (parse_phase) inside
        PH_VERSION: begin
          if (b != expected_version) begin
            first_error_next = VC_VERSION;
            has_failed_next  = 1'b1;
          end else begin
            parse_phase_next = PH_KIND;
          end
        end
        PH_KIND: begin
          if (b > 8'd1) begin
            first_error_next = VC_KIND;
            has_failed_next  = 1'b1;
          end else begin
            record_is_delete_next = b[0];
            fld_valid             = 1'b1;
            fld_kind              = FK_KIND;
            fld_value             = {56'd0, b};
            parse_phase_next      = PH_COUNTER;
            byte_in_field_next    = '0;
          end
        end
        PH_COUNTER, PH_PCOUNTER: begin
          field_accumulator_next = acc_g;
          if (bif_inc >= WORD_N) begin
            byte_in_field_next = '0;
            if (parse_phase == PH_PCOUNTER) begin
              fld_valid        = 1'b1;
              fld_kind         = FK_PCOUNTER;
              fld_value        = acc_g;
              parse_phase_next = PH_PREPLICA;
            end else if (acc_g == 64'd0) begin
              first_error_next = VC_ZERO_CTR;
              has_failed_next  = 1'b1;
            end else begin
              fld_valid        = 1'b1;
              fld_kind         = FK_COUNTER;
              fld_value        = acc_g;
              parse_phase_next = PH_REPLICA;
            end
          end else begin
            byte_in_field_next = bif_inc[BW-1:0];
          end
        end
        PH_REPLICA, PH_PREPLICA: begin
          fld_valid = 1'b1;
          fld_kind  = (parse_phase == PH_REPLICA) ? FK_REPLICA : FK_PREPLICA;
          fld_value = {56'd0, b};
          if (bif_inc >= REP_N) begin
            byte_in_field_next = '0;
            if (parse_phase == PH_PREPLICA)
              parse_phase_next = PH_SIDE;
            else
              parse_phase_next = record_is_delete ? PH_COUNT : PH_PCOUNTER;
          end else begin
            byte_in_field_next = bif_inc[BW-1:0];
          end
        end
        PH_SIDE: begin
          if (b > 8'd1) begin
            first_error_next = VC_SIDE;
            has_failed_next  = 1'b1;
          end else begin
            fld_valid          = 1'b1;
            fld_kind           = FK_SIDE;
            fld_value          = {56'd0, b};
            parse_phase_next   = PH_LENGTH;
            byte_in_field_next = '0;
          end
        end
        PH_LENGTH, PH_CHARS, PH_COUNT: begin
          field_accumulator_next = acc_g;
          if (bif_inc >= HALF_N) begin
            byte_in_field_next = '0;
            if (parse_phase == PH_LENGTH) begin
              if (cp == 32'd0) begin
                first_error_next = VC_ZERO_LEN;
                has_failed_next  = 1'b1;
              end else begin
                chars_remaining_next = cp;
                fld_valid            = 1'b1;
                fld_kind             = FK_LENGTH;
                fld_value            = {32'd0, cp};
                parse_phase_next     = PH_CHARS;
              end
            end else if (parse_phase == PH_COUNT) begin
              if (cp == 32'd0) begin
                first_error_next = VC_ZERO_COUNT;
                has_failed_next  = 1'b1;
              end else begin
                fld_valid        = 1'b1;
                fld_kind         = FK_COUNT;
                fld_value        = {32'd0, cp};
                parse_phase_next = PH_DONE;
              end
            end else if (cp > CP_MAX) begin
              first_error_next = VC_RANGE;
              has_failed_next  = 1'b1;
            end else if (cp >= CP_SURR_FIRST && cp <= CP_SURR_LAST) begin
              first_error_next = VC_SURROGATE;
              has_failed_next  = 1'b1;
            end else begin
              fld_valid            = 1'b1;
              fld_kind             = FK_CODEPOINT;
              fld_value            = {32'd0, cp};
              chars_remaining_next = chars_dec;
              if (chars_dec == 32'd0)
                parse_phase_next = PH_DONE;
            end
          end else begin
            byte_in_field_next = bif_inc[BW-1:0];
          end
        end
        // Complete record, or an impossible phase: any more bytes trail
        default: begin
          first_error_next = VC_TRAILING;
          has_failed_next  = 1'b1;
        end
      endcase
    end

    // Verdict from the state this byte leaves
    if (has_failed_next)
      verdict = first_error_next;
    else if (parse_phase_next >= PH_DONE)
      verdict = VC_OK;
    else
      verdict = VC_TRUNCATED;

    // Final byte closes the payload
    if (last) begin
      parse_phase_next       = PH_VERSION;
      byte_in_field_next     = '0;
      field_accumulator_next = 64'd0;
      record_is_delete_next  = 1'b0;
      chars_remaining_next   = 32'd0;
      first_error_next       = VC_OK;
      has_failed_next        = 1'b0;
    end
  end

  // Queue entries for this byte: field first, then verdict
  always_comb begin
    out_item_t fld_item;
    out_item_t vrd_item;
    fld_item.field_kind   = fld_kind;
    fld_item.field_value  = fld_value;
    fld_item.verdict_code = VC_OK;
    fld_item.record_end   = 1'b0;
    vrd_item.field_kind   = FK_VERDICT;
    vrd_item.field_value  = 64'd0;
    vrd_item.verdict_code = verdict;
    vrd_item.record_end   = 1'b1;
    ent0     = fld_valid ? fld_item : vrd_item;
    ent1     = vrd_item;
    push_cnt = in_fire ? ({1'b0, fld_valid} + {1'b0, last}) : 2'd0;
  end

  // Parse state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version  <= DEF_EXPECTED_VERSION;
      parse_phase       <= PH_VERSION;
      byte_in_field     <= '0;
      field_accumulator <= 64'd0;
      record_is_delete  <= 1'b0;
      chars_remaining   <= 32'd0;
      first_error       <= VC_OK;
      has_failed        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        expected_version <= cfg_data;
      end
      if (in_fire) begin
        parse_phase       <= parse_phase_next;
        byte_in_field     <= byte_in_field_next;
        field_accumulator <= field_accumulator_next;
        record_is_delete  <= record_is_delete_next;
        chars_remaining   <= chars_remaining_next;
        first_error       <= first_error_next;
        has_failed        <= has_failed_next;
      end
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      queue[wr_ptr] <= ent0;
    end
    if (push_cnt == 2'd2) begin
      queue[wr_ptr + 2'd1] <= ent1;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push_cnt;
      if (out_fire) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + {1'b0, push_cnt} - {2'd0, out_fire};
    end
  end

endmodule

// ----- bench/tb_edit_op_record_decoder.sv -----
`timescale 1ns / 1ps

import erd_pkg::*;

// Parser position within one record
typedef enum logic [3:0] {
  P_VERSION, P_KIND, P_COUNTER, P_REPLICA, P_PCOUNTER, P_PREPLICA,
  P_SIDE, P_LENGTH, P_CHARS, P_COUNT, P_DONE
} parse_pos_e;

// Mirrors the record parser and holds the fields it should emit, oldest first
class record_field_board;
  out_item_t   fields_due[$];
  int          errors = 0;
  logic [7:0]  version = DEF_EXPECTED_VERSION;
  parse_pos_e  pos = P_VERSION;
  int          byte_idx = 0;
  logic [63:0] acc = '0;
  logic        is_delete = 1'b0;
  logic [31:0] chars_left = '0;
  logic [3:0]  first_err = VC_OK;
  logic        failed = 1'b0;

  function void clear_parse();
    pos = P_VERSION;
    byte_idx = 0;
    acc = '0;
    is_delete = 1'b0;
    chars_left = '0;
    first_err = VC_OK;
    failed = 1'b0;
  endfunction

  function void flag(logic [3:0] code);
    first_err = code;
    failed = 1'b1;
  endfunction

  function void add(logic [3:0] kind, logic [63:0] value, logic [3:0] code, logic last);
    out_item_t f;
    f.field_kind = kind;
    f.field_value = value;
    f.verdict_code = code;
    f.record_end = last;
    fields_due = {fields_due, f};
  endfunction

  // little-endian gather; true once n bytes are in
  function bit collect(logic [7:0] b, int n);
    if (byte_idx == 0) acc = '0;
    acc = acc | (64'(b) << (8 * (byte_idx % 8)));
    byte_idx++;
    if (byte_idx >= n) begin
      byte_idx = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function bit replica_last();
    byte_idx++;
    if (byte_idx >= DEF_REPLICA_BYTES) begin
      byte_idx = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // one accepted input beat
  function void note_byte(in_item_t it);
    logic [7:0] b;
    logic [3:0] code;
    b = it.data_byte;
    if (!failed) begin
      case (pos)
        P_VERSION: begin
          if (b != version) flag(VC_VERSION);
          else pos = P_KIND;
        end
        P_KIND: begin
          if (b > 8'd1) flag(VC_KIND);
          else begin
            is_delete = b[0];
            add(FK_KIND, 64'(b), VC_OK, 1'b0);
            pos = P_COUNTER;
            byte_idx = 0;
          end
        end
        P_COUNTER: begin
          if (collect(b, 8)) begin
            if (acc == '0) flag(VC_ZERO_CTR);
            else begin
              add(FK_COUNTER, acc, VC_OK, 1'b0);
              pos = P_REPLICA;
            end
          end
        end
        P_REPLICA: begin
          add(FK_REPLICA, 64'(b), VC_OK, 1'b0);
          if (replica_last()) pos = is_delete ? P_COUNT : P_PCOUNTER;
        end
        P_PCOUNTER: begin
          if (collect(b, 8)) begin
            add(FK_PCOUNTER, acc, VC_OK, 1'b0);
            pos = P_PREPLICA;
          end
        end
        P_PREPLICA: begin
          add(FK_PREPLICA, 64'(b), VC_OK, 1'b0);
          if (replica_last()) pos = P_SIDE;
        end
        P_SIDE: begin
          if (b > 8'd1) flag(VC_SIDE);
          else begin
            add(FK_SIDE, 64'(b), VC_OK, 1'b0);
            pos = P_LENGTH;
            byte_idx = 0;
          end
        end
        P_LENGTH: begin
          if (collect(b, 4)) begin
            if (acc == '0) flag(VC_ZERO_LEN);
            else begin
              chars_left = acc[31:0];
              add(FK_LENGTH, acc, VC_OK, 1'b0);
              pos = P_CHARS;
            end
          end
        end
        P_CHARS: begin
          if (collect(b, 4)) begin
            if (acc > 64'(CP_MAX)) flag(VC_RANGE);
            else if (acc >= 64'(CP_SURR_FIRST) && acc <= 64'(CP_SURR_LAST)) flag(VC_SURROGATE);
            else begin
              add(FK_CODEPOINT, acc, VC_OK, 1'b0);
              if (chars_left > 0) chars_left--;
              if (chars_left == 0) pos = P_DONE;
            end
          end
        end
        P_COUNT: begin
          if (collect(b, 4)) begin
            if (acc == '0) flag(VC_ZERO_COUNT);
            else begin
              add(FK_COUNT, acc, VC_OK, 1'b0);
              pos = P_DONE;
            end
          end
        end
        default: flag(VC_TRAILING);
      endcase
    end
    // closing verdict
    if (it.end_of_payload) begin
      if (failed) code = first_err;
      else if (pos == P_DONE) code = VC_OK;
      else code = VC_TRUNCATED;
      add(FK_VERDICT, '0, code, 1'b1);
      clear_parse();
    end
  endfunction

  function void compare(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endfunction

  // one accepted output beat
  function void check_result(out_item_t got);
    out_item_t want;
    if (fields_due.size() == 0) begin
      $display("%0t: unexpected beat: expected none, got kind %0d value %h verdict %0d end %0b",
               $time, got.field_kind, got.field_value, got.verdict_code, got.record_end);
      errors++;
      return;
    end
    want = fields_due.pop_front();
    compare("field_kind", 64'(want.field_kind), 64'(got.field_kind));
    compare("field_value", want.field_value, got.field_value);
    compare("verdict_code", 64'(want.verdict_code), 64'(got.verdict_code));
    compare("record_end", 64'(want.record_end), 64'(got.record_end));
  endfunction
endclass

module tb_edit_op_record_decoder;

  // Kinds of damage applied to a generated record
  typedef enum int {
    F_NONE, F_VERSION, F_KIND, F_ZERO_CTR, F_SIDE, F_ZERO_LEN,
    F_RANGE, F_SURR, F_ZERO_COUNT, F_TRAIL, F_TRUNC
  } fault_e;

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_BYTES = 160;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = '0;

  record_field_board sb;
  logic [7:0] payload_q[$];
  logic [7:0] cur_version = DEF_EXPECTED_VERSION;
  int idle_pct = 0;
  int stall_pct = 0;
  int bytes_sent = 0;
  int idle_cycles = 0;
  int hold_asked = 0;
  int hold_served = 0;

  edit_op_record_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial forever #1 clk = ~clk;

  // Receiver: random stalls, plus long hold-offs on request
  initial forever begin
    @(posedge clk);
    if (hold_asked != hold_served) begin
      hold_served = hold_asked;
      out_ready <= 1'b0;
      repeat (HOLD_CYCLES - 1) @(posedge clk);
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Output check and progress count
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  // Watchdog
  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_counter();
    logic [63:0] v;
    case ($urandom_range(7))
      0: v = 64'd1;
      1: v = '1;
      default: do v = rand64(); while (v == '0);
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rand_count();
    logic [31:0] v;
    do v = $urandom; while (v == '0);
    return v;
  endfunction

  function automatic logic [31:0] good_cp();
    case ($urandom_range(5))
      0: return $urandom_range(0, 32'hD7FF);
      1: return $urandom_range(32'hE000, CP_MAX);
      2: return CP_MAX;
      3: return 32'h0;
      4: return CP_SURR_FIRST - 1;
      default: return CP_SURR_LAST + 1;
    endcase
  endfunction

  // one byte onto the end of the payload being built
  task automatic append_byte(input logic [7:0] v);
    payload_q = {payload_q, v};
  endtask

  task automatic push_le(input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) append_byte(v[8*i +: 8]);
  endtask

  // version, kind, counter and replica bytes
  task automatic head(input logic del, input logic [63:0] ctr);
    payload_q.delete();
    push_le(64'(cur_version), 1);
    push_le(64'(del), 1);
    push_le(ctr, 8);
    repeat (DEF_REPLICA_BYTES) append_byte(8'($urandom_range(255)));
  endtask

  // parent id, side and length of an insert
  task automatic insert_body(input logic [63:0] pctr, input logic [7:0] side, input logic [31:0] len);
    push_le(pctr, 8);
    repeat (DEF_REPLICA_BYTES) append_byte(8'($urandom_range(255)));
    push_le(64'(side), 1);
    push_le(64'(len), 4);
  endtask

  task automatic send_byte(input in_item_t it);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(it);
    bytes_sent++;
  endtask

  task automatic send_payload();
    in_item_t it;
    for (int i = 0; i < payload_q.size(); i++) begin
      it.data_byte = payload_q[i];
      it.end_of_payload = (i == payload_q.size() - 1);
      send_byte(it);
    end
  endtask

  // let every expected beat arrive, then a short settle
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (sb.fields_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_version(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.version = v;
    cur_version = v;
  endtask

  // mostly well-formed records, some damaged, some plain noise
  task automatic build_random();
    int r;
    int nchars;
    int bad_at;
    int cut;
    fault_e f;
    logic del;
    logic [31:0] cp;
    r = $urandom_range(99);
    if (r >= 90) begin
      payload_q.delete();
      repeat ($urandom_range(1, 8)) append_byte(8'($urandom_range(255)));
      return;
    end
    f = (r >= 55) ? fault_e'($urandom_range(F_VERSION, F_TRUNC)) : F_NONE;
    case (f) inside
      F_SIDE, F_ZERO_LEN, F_RANGE, F_SURR: del = 1'b0;
      F_ZERO_COUNT: del = 1'b1;
      default: del = 1'($urandom_range(1));
    endcase
    nchars = ($urandom_range(9) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
    bad_at = $urandom_range(nchars - 1);
    head(del, (f == F_ZERO_CTR) ? 64'd0 : rand_counter());
    if (f == F_VERSION) payload_q[0] = cur_version ^ 8'($urandom_range(1, 255));
    if (f == F_KIND) payload_q[1] = 8'($urandom_range(2, 255));
    if (del) begin
      push_le(64'((f == F_ZERO_COUNT) ? 32'd0 : rand_count()), 4);
    end else begin
      insert_body(($urandom_range(3) == 0) ? 64'd0 : rand64(),
                  (f == F_SIDE) ? 8'($urandom_range(2, 255)) : 8'($urandom_range(1)),
                  (f == F_ZERO_LEN) ? 32'd0 : 32'(nchars));
      for (int i = 0; i < nchars; i++) begin
        if (i == bad_at && f == F_RANGE) cp = $urandom_range(CP_MAX + 1, 32'hFFFF_FFFF);
        else if (i == bad_at && f == F_SURR) cp = $urandom_range(CP_SURR_FIRST, CP_SURR_LAST);
        else cp = good_cp();
        push_le(64'(cp), 4);
      end
    end
    if (f == F_TRAIL) repeat ($urandom_range(1, 4)) append_byte(8'($urandom_range(255)));
    if (f == F_TRUNC) begin
      cut = $urandom_range(1, payload_q.size() - 1);
      while (payload_q.size() > cut) void'(payload_q.pop_back());
    end
  endtask

  initial begin
    int phase_end;
    int idle_tab[4];
    int stall_tab[4];
    idle_tab = '{0, 78, 0, 35};
    stall_tab = '{0, 0, 78, 35};
    sb = new;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_version(DEF_EXPECTED_VERSION);

    // Directed records
    idle_pct = 35;
    stall_pct = 35;
    // insert with smallest counter, zero parent counter, one zero code point
    head(1'b0, 64'd1); insert_body(64'd0, 8'd0, 32'd1); push_le(64'd0, 4); send_payload();
    // insert with all-ones counters, right side, code points at the range edges
    head(1'b0, '1); insert_body('1, 8'd1, 32'd3);
    push_le(64'(CP_MAX), 4); push_le(64'(CP_SURR_FIRST - 1), 4);
    push_le(64'(CP_SURR_LAST + 1), 4); send_payload();
    // deletes with smallest and largest count
    head(1'b1, '1); push_le(64'd1, 4); send_payload();
    head(1'b1, rand_counter()); push_le(64'hFFFF_FFFF, 4); send_payload();
    // wrong version, bytes after it consumed silently
    head(1'b1, 64'd5); push_le(64'd3, 4); payload_q[0] = ~cur_version; send_payload();
    // bad kind bytes
    head(1'b0, 64'd7); payload_q[1] = 8'd2; send_payload();
    head(1'b0, 64'd7); payload_q[1] = 8'hFF; send_payload();
    // zero counter on a delete
    head(1'b1, 64'd0); push_le(64'd3, 4); send_payload();
    // bad side, zero length
    head(1'b0, 64'd9); insert_body(64'd3, 8'd2, 32'd1); push_le(64'd65, 4); send_payload();
    head(1'b0, 64'd9); insert_body(64'd3, 8'hFF, 32'd1); push_le(64'd65, 4); send_payload();
    head(1'b0, 64'd9); insert_body(64'd3, 8'd0, 32'd0); send_payload();
    // code point just above the range and all ones
    head(1'b0, 64'd2); insert_body(64'd1, 8'd1, 32'd2);
    push_le(64'd66, 4); push_le(64'(CP_MAX + 1), 4); send_payload();
    head(1'b0, 64'd2); insert_body(64'd1, 8'd1, 32'd1); push_le(64'hFFFF_FFFF, 4); send_payload();
    // surrogate bounds
    head(1'b0, 64'd2); insert_body(64'd1, 8'd0, 32'd1); push_le(64'(CP_SURR_FIRST), 4);
    send_payload();
    head(1'b0, 64'd2); insert_body(64'd1, 8'd0, 32'd1); push_le(64'(CP_SURR_LAST), 4);
    send_payload();
    // zero count
    head(1'b1, 64'd4); push_le(64'd0, 4); send_payload();
    // trailing bytes after a complete delete
    head(1'b1, 64'd4); push_le(64'd8, 4); push_le(64'hA55A, 2); send_payload();
    // truncated: version byte alone, then mid counter
    payload_q.delete(); append_byte(cur_version); send_payload();
    head(1'b1, 64'd6); while (payload_q.size() > 5) void'(payload_q.pop_back()); send_payload();
    // huge length, payload ends after two code points
    head(1'b0, 64'd3); insert_body(64'd0, 8'd1, 32'hFFFF_FFFF);
    push_le(64'd97, 4); push_le(64'd98, 4); send_payload();
    wait_for_drain();

    // Random records over several flow-control settings and versions
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: write_version(8'hFF);
        1: write_version(8'h00);
        2: write_version(8'($urandom_range(255)));
        default: write_version(DEF_EXPECTED_VERSION);
      endcase
      idle_pct = idle_tab[p];
      stall_pct = stall_tab[p];
      // long consumer hold-off while bytes keep coming, to back up the input
      if (p == 0) hold_asked++;
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) begin
        build_random();
        send_payload();
      end
      wait_for_drain();
    end

    if (sb.errors == 0 && sb.fields_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      if (sb.fields_due.size() != 0)
        $display("%0t: %0d expected beats never arrived", $time, sb.fields_due.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/erd_pkg.sv
rtl/core/edit_op_record_decoder.sv
bench/tb_edit_op_record_decoder.sv
